>>> hdl/tms_pkg.sv
// ----------------------------------------------------------------------------
// tms_pkg
// Shared types and constants of the Turing machine stepper.
// ----------------------------------------------------------------------------
package tms_pkg;

    localparam int TMS_TAPE_CELLS = 1048576;
    localparam int TMS_EDGE_GUARD = 8;
    localparam int TMS_OUT_DEPTH  = 4;

    localparam int TMS_TABLE_W  = 40;
    localparam int TMS_TARGET_W = 3;
    localparam int TMS_STEP_W   = 48;
    localparam int TMS_OFS_W    = 20;
    localparam int TMS_IDX_W    = 2;
    localparam int TMS_CFG_W    = 48;

    // register indexes of the configuration channel
    localparam logic [TMS_IDX_W-1:0] TMS_CFG_TABLE  = 2'd0;
    localparam logic [TMS_IDX_W-1:0] TMS_CFG_TARGET = 2'd1;
    localparam logic [TMS_IDX_W-1:0] TMS_CFG_BUDGET = 2'd2;

    typedef enum logic [1:0] {
        KIND_FIRE   = 2'd0,
        KIND_HALT   = 2'd1,
        KIND_EDGE   = 2'd2,
        KIND_BUDGET = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind                        kind;
        logic [TMS_STEP_W-1:0]        step_count;
        logic signed [TMS_OFS_W-1:0]  head_offset;
        logic signed [TMS_OFS_W-1:0]  low_extent;
        logic signed [TMS_OFS_W-1:0]  high_extent;
        logic                         last;
    } t_result;

    // reports produced by one step, res0 first
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_push;

endpackage

>>> hdl/tms_ram.sv
// ----------------------------------------------------------------------------
// tms_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module tms_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic [WIDTH-1:0]         o_rdata_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

>>> hdl/tms_core.sv
// ----------------------------------------------------------------------------
// tms_core
// Machine state, head, extent, step counter and the tape. The cells at
// head-1, head and head+1 live in flops; the RAM prefetches head-2 and
// head+2 so that a step can follow in every cycle.
// ----------------------------------------------------------------------------
module tms_core #(
    parameter int TAPE_CELLS = tms_pkg::TMS_TAPE_CELLS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_run,
    input  logic [tms_pkg::TMS_TABLE_W-1:0]   i_table,
    input  logic [tms_pkg::TMS_TARGET_W-1:0]  i_target,
    input  logic [tms_pkg::TMS_STEP_W-1:0]    i_budget,
    output tms_pkg::t_push                    o_push
);

    localparam int AW = $clog2(TAPE_CELLS);
    localparam int OW = tms_pkg::TMS_OFS_W;
    localparam int RW = (AW > OW) ? AW : OW;
    localparam logic [AW-1:0] CENTER  = AW'(TAPE_CELLS / 2);
    localparam logic [AW-1:0] EDGE_LO = AW'(tms_pkg::TMS_EDGE_GUARD);
    localparam logic [AW-1:0] EDGE_HI = AW'(TAPE_CELLS - tms_pkg::TMS_EDGE_GUARD);
    localparam logic [AW-1:0] TWO     = AW'(2);

    logic [1:0]                    r_state, n_state;
    logic [AW-1:0]                 r_head, n_head;
    logic [AW-1:0]                 r_low, n_low;
    logic [AW-1:0]                 r_high, n_high;
    logic [tms_pkg::TMS_STEP_W-1:0] r_steps, n_steps;
    logic                          r_finished, n_finished;
    logic                          r_cm1, n_cm1;
    logic                          r_c0, n_c0;
    logic                          r_cp1, n_cp1;
    logic                          r_okm, r_okp;

    logic [AW-1:0] w_addr_m, w_addr_p;
    logic          w_rd_m, w_rd_p;
    logic          w_active, w_budget_met, w_halt, w_fire, w_move;
    logic          w_edge, w_end2;
    logic [2:0]    w_instr;
    logic [4:0]    w_entry;
    logic [AW-1:0] w_head_mv;
    logic [tms_pkg::TMS_STEP_W-1:0] w_steps_inc;
    tms_pkg::t_result w_pre, w_post;

    function automatic logic [OW-1:0] rel(input logic [AW-1:0] pos);
        logic [RW-1:0] d;
        d = RW'(pos) - RW'(CENTER);
        return d[OW-1:0];
    endfunction

    assign w_active     = i_run && !r_finished;
    assign w_budget_met = r_steps >= i_budget;
    assign w_instr      = {r_state, r_c0};
    assign w_entry      = i_table[5*w_instr +: 5];
    assign w_halt       = w_entry[4];
    assign w_fire       = (w_instr == i_target);
    assign w_head_mv    = w_entry[1] ? (r_head + AW'(1)) : (r_head - AW'(1));
    assign w_steps_inc  = r_steps + tms_pkg::TMS_STEP_W'(1);
    assign w_move       = w_active && !w_budget_met && !w_halt;

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_low      = r_low;
        n_high     = r_high;
        n_steps    = r_steps;
        n_finished = r_finished;
        n_cm1      = r_cm1;
        n_c0       = r_c0;
        n_cp1      = r_cp1;
        if (w_active && (w_budget_met || w_halt)) begin
            n_finished = 1'b1;
        end
        if (w_move) begin
            n_state = w_entry[3:2];
            n_head  = w_head_mv;
            n_steps = w_steps_inc;
            if (w_head_mv < r_low) begin
                n_low = w_head_mv;
            end
            if (w_head_mv > r_high) begin
                n_high = w_head_mv;
            end
            if (w_edge || w_end2) begin
                n_finished = 1'b1;
            end
            if (w_entry[1]) begin
                n_cm1 = w_entry[0];
                n_c0  = r_cp1;
                n_cp1 = w_rd_p & r_okp;
            end else begin
                n_cp1 = w_entry[0];
                n_c0  = r_cm1;
                n_cm1 = w_rd_m & r_okm;
            end
        end
    end

    assign w_edge = (w_head_mv < EDGE_LO) || (w_head_mv >= EDGE_HI);
    assign w_end2 = !w_edge && (w_steps_inc >= i_budget);

    // every visited cell other than the head has been written, so a
    // prefetched cell is only real if it lies inside the new extent
    assign w_addr_m = n_head - TWO;
    assign w_addr_p = n_head + TWO;

    tms_ram #(
        .WIDTH (1),
        .DEPTH (TAPE_CELLS)
    ) u_tape (
        .i_clk     (i_clk),
        .i_we      (w_move),
        .i_waddr   (r_head),
        .i_wdata   (w_entry[0]),
        .i_raddr_a (w_addr_m),
        .o_rdata_a (w_rd_m),
        .i_raddr_b (w_addr_p),
        .o_rdata_b (w_rd_p)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= 2'd0;
            r_head     <= CENTER;
            r_low      <= CENTER;
            r_high     <= CENTER;
            r_steps    <= '0;
            r_finished <= 1'b0;
            r_cm1      <= 1'b0;
            r_c0       <= 1'b0;
            r_cp1      <= 1'b0;
            r_okm      <= 1'b0;
            r_okp      <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_head     <= n_head;
            r_low      <= n_low;
            r_high     <= n_high;
            r_steps    <= n_steps;
            r_finished <= n_finished;
            r_cm1      <= n_cm1;
            r_c0       <= n_c0;
            r_cp1      <= n_cp1;
            r_okm      <= (w_addr_m >= n_low) && (w_addr_m <= n_high);
            r_okp      <= (w_addr_p >= n_low) && (w_addr_p <= n_high);
        end
    end

    // report built from the state before the step
    always_comb begin
        w_pre.kind        = w_budget_met ? tms_pkg::KIND_BUDGET
                          : (w_halt ? tms_pkg::KIND_HALT : tms_pkg::KIND_FIRE);
        w_pre.step_count  = r_steps;
        w_pre.head_offset = (w_budget_met || w_halt) ? '0 : $signed(rel(r_head));
        w_pre.low_extent  = $signed(rel(r_low));
        w_pre.high_extent = $signed(rel(r_high));
        w_pre.last        = 1'b0;
    end

    // end report after a step: edge or budget
    always_comb begin
        w_post.kind        = w_edge ? tms_pkg::KIND_EDGE : tms_pkg::KIND_BUDGET;
        w_post.step_count  = w_steps_inc;
        w_post.head_offset = '0;
        w_post.low_extent  = $signed(rel(n_low));
        w_post.high_extent = $signed(rel(n_high));
        w_post.last        = 1'b1;
    end

    always_comb begin
        o_push.count = 2'd0;
        o_push.res0  = w_pre;
        o_push.res1  = w_post;
        if (w_active) begin
            if (w_budget_met || w_halt) begin
                o_push.count     = 2'd1;
                o_push.res0.last = 1'b1;
            end else if (w_fire) begin
                o_push.count     = (w_edge || w_end2) ? 2'd2 : 2'd1;
                o_push.res0.last = !(w_edge || w_end2);
            end else if (w_edge || w_end2) begin
                o_push.count = 2'd1;
                o_push.res0  = w_post;
            end
        end
    end

endmodule

>>> hdl/tms_out_fifo.sv
// ----------------------------------------------------------------------------
// tms_out_fifo
// Result queue: takes up to two reports per cycle, hands out one per
// transaction on the output stream.
// ----------------------------------------------------------------------------
module tms_out_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tms_pkg::t_push   i_push,
    output logic             o_space2,
    output logic [2:0]       o_level,
    output tms_pkg::t_result o_head,
    output logic             o_valid,
    input  logic             i_ready
);

    localparam int DEPTH = tms_pkg::TMS_OUT_DEPTH;
    localparam int PW    = $clog2(DEPTH);

    tms_pkg::t_result r_mem [DEPTH];
    logic [PW-1:0]    r_wr, n_wr;
    logic [PW-1:0]    r_rd, n_rd;
    logic [PW:0]      r_count, n_count;
    logic             w_pop;

    assign w_pop = o_valid && i_ready;

    always_comb begin
        n_wr    = r_wr + PW'(i_push.count);
        n_rd    = r_rd + PW'(w_pop);
        n_count = r_count + (PW+1)'(i_push.count) - (PW+1)'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.res0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wr + PW'(1)] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    assign o_valid  = (r_count != '0);
    assign o_head   = r_mem[r_rd];
    assign o_space2 = (r_count <= (PW+1)'(DEPTH - 2));
    assign o_level  = 3'(r_count);

endmodule

>>> hdl/turing_machine_stepper_top.sv
// ----------------------------------------------------------------------------
// turing_machine_stepper_top
// Four-state, two-symbol Turing machine stepper with a streaming interface.
// ----------------------------------------------------------------------------
// A report is registered in the result queue and leaves once earlier ones are taken.
// Throughput: one machine step per cycle, set by the tape read-modify-write
//   (three cells in flops, dual-read RAM prefetching head-2 and head+2).
// Input stalls while the result queue has room for fewer than two reports.
// Reset (synchronous, active low) clears control state; no tape clearing
// pass: a cell outside the visited extent reads as zero.
// ----------------------------------------------------------------------------
module turing_machine_stepper_top #(
    parameter int TAPE_CELLS = tms_pkg::TMS_TAPE_CELLS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,  // [0] run
    // result stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [47:0] step_count, [67:48] head_offset, [87:68] low_extent,
    // [107:88] high_extent, [111:108] zero
    output logic [111:0]                     m_axis_tdata,
    output logic [1:0]                       m_axis_tuser,  // [1:0] kind
    output logic                             m_axis_tlast,
    // configuration writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [tms_pkg::TMS_IDX_W-1:0]    i_cfg_index,
    input  logic [tms_pkg::TMS_CFG_W-1:0]    i_cfg_data
);

    logic [tms_pkg::TMS_TABLE_W-1:0]  r_table;
    logic [tms_pkg::TMS_TARGET_W-1:0] r_target;
    logic [tms_pkg::TMS_STEP_W-1:0]   r_budget;

    tms_pkg::t_push   w_push;
    tms_pkg::t_result w_head;
    logic             w_space2;
    logic [2:0]       w_level;
    logic             w_run;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table  <= '0;
            r_target <= '0;
            r_budget <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tms_pkg::TMS_CFG_TABLE:  r_table  <= i_cfg_data[tms_pkg::TMS_TABLE_W-1:0];
                tms_pkg::TMS_CFG_TARGET: r_target <= i_cfg_data[tms_pkg::TMS_TARGET_W-1:0];
                tms_pkg::TMS_CFG_BUDGET: r_budget <= i_cfg_data[tms_pkg::TMS_STEP_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_axis_tready = w_space2;
    assign w_run         = s_axis_tvalid && s_axis_tready && s_axis_tdata[0];

    tms_core #(
        .TAPE_CELLS (TAPE_CELLS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_run    (w_run),
        .i_table  (r_table),
        .i_target (r_target),
        .i_budget (r_budget),
        .o_push   (w_push)
    );

    tms_out_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .o_space2 (w_space2),
        .o_level  (w_level),
        .o_head   (w_head),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready)
    );

    assign m_axis_tdata = {4'b0000, w_head.high_extent, w_head.low_extent,
                           w_head.head_offset, w_head.step_count};
    assign m_axis_tuser = w_head.kind;
    assign m_axis_tlast = w_head.last;

    // queue never overfills
    a_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_level <= 3'(tms_pkg::TMS_OUT_DEPTH))
        else $error("result queue overflow");

    // a pair of reports is a fire followed by the closing end report
    a_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push.count == 2'd2) |-> (w_push.res0.kind == tms_pkg::KIND_FIRE
            && !w_push.res0.last && w_push.res1.last
            && w_push.res1.kind != tms_pkg::KIND_FIRE))
        else $error("bad report pair");

    // a single report that closes the run carries last
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push.count == 2'd1 && w_push.res0.kind != tms_pkg::KIND_FIRE)
            |-> w_push.res0.last)
        else $error("end report without last");

    // no reports pushed without an accepted run transaction
    a_push_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push.count != 2'd0) |-> w_run)
        else $error("report without run");

endmodule

>>> tb/turing_machine_stepper_top_tb.sv
// ----------------------------------------------------------------------------
// turing_machine_stepper_top_tb
// Self-checking bench for the Turing machine stepper. A predictor in the
// bench steps its own copy of the machine on every accepted run transaction
// and queues the expected reports. Each report on the master stream is
// compared field by field with the oldest one queued. Both streams idle at
// random, and one long receiver hold-off fills the block so that it stalls
// its input. Rule tables, targets and budgets change between phases. The
// run ends on the step budget, after which further run ticks must be silent.
// ----------------------------------------------------------------------------
module turing_machine_stepper_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tms_pkg::*;

    localparam int          CLK_PERIOD   = 4;
    localparam int          LIMIT_CYCLES = 1000000;
    localparam int          LONG_HOLD    = 300;
    localparam int          RUN_TARGET   = 1150;
    localparam int          FIRE_TARGET  = 48;
    localparam int unsigned CENTER       = TMS_TAPE_CELLS / 2;
    localparam logic [TMS_TABLE_W-1:0] NO_HALT_MASK = {8{5'b01111}};
    localparam logic [TMS_STEP_W-1:0]  BUDGET_MAX   = '1;

    logic         i_clk    = 1'b0;
    logic         i_rst_n  = 1'b0;

    logic         s_valid  = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_data   = 8'd0;

    logic         m_axis_tvalid;
    logic         m_ready  = 1'b0;
    logic [111:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         m_axis_tlast;

    logic                  cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [TMS_IDX_W-1:0]  cfg_index = '0;
    logic [TMS_CFG_W-1:0]  cfg_data  = '0;

    turing_machine_stepper_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // machine copy kept by the predictor
    logic [TMS_TABLE_W-1:0]  rule_table = '0;
    logic [TMS_TARGET_W-1:0] target_reg = '0;
    logic [TMS_STEP_W-1:0]   budget_reg = '0;
    bit                      tape_mem [int unsigned];
    logic [1:0]              mstate     = 2'd0;
    int unsigned             head_pos   = CENTER;
    int unsigned             low_pos    = CENTER;
    int unsigned             high_pos   = CENTER;
    logic [TMS_STEP_W-1:0]   steps_done = '0;
    bit                      halted     = 1'b0;

    t_result     expected_reports[$];
    logic        pending_runs[$];
    t_result     oldest_report;
    int          errors       = 0;
    int          fires_queued = 0;
    int          runs_queued  = 0;
    int          gap_max      = 0;
    int          stall_max    = 0;
    int          gap_cnt      = 0;
    int          stall_cnt    = 0;
    int          hold_cnt     = 0;
    int unsigned recv_draw;
    bit          hold_wanted  = 1'b0;
    bit          hold_done    = 1'b0;
    int          cycle_count  = 0;

    function automatic logic [TMS_OFS_W-1:0] rel_cell(int unsigned pos);
        return TMS_OFS_W'(pos - CENTER);
    endfunction

    function automatic t_result make_report(t_kind kind, logic [TMS_STEP_W-1:0] step,
                                            logic [TMS_OFS_W-1:0] head);
        t_result rpt;
        rpt.kind        = kind;
        rpt.step_count  = step;
        rpt.head_offset = head;
        rpt.low_extent  = rel_cell(low_pos);
        rpt.high_extent = rel_cell(high_pos);
        rpt.last        = 1'b0;
        return rpt;
    endfunction

    // one tick of the machine; queues the reports it causes, last one flagged
    task automatic step_machine(input logic run);
        t_result     tick_q[$];
        bit          sym;
        logic [2:0]  instr;
        logic [4:0]  entry;
        if (run && !halted) begin
            if (steps_done >= budget_reg) begin
                tick_q.push_back(make_report(KIND_BUDGET, steps_done, '0));
                halted = 1'b1;
            end else begin
                sym   = tape_mem.exists(head_pos) ? tape_mem[head_pos] : 1'b0;
                instr = {mstate, sym};
                entry = rule_table[5*instr +: 5];
                if (entry[4]) begin
                    tick_q.push_back(make_report(KIND_HALT, steps_done, '0));
                    halted = 1'b1;
                end else begin
                    if (instr == target_reg) begin
                        tick_q.push_back(make_report(KIND_FIRE, steps_done,
                                                     rel_cell(head_pos)));
                        fires_queued++;
                    end
                    tape_mem[head_pos] = entry[0];
                    head_pos   = entry[1] ? head_pos + 1 : head_pos - 1;
                    mstate     = entry[3:2];
                    steps_done = steps_done + 1'b1;
                    if (head_pos < low_pos)
                        low_pos = head_pos;
                    if (head_pos > high_pos)
                        high_pos = head_pos;
                    if (head_pos < TMS_EDGE_GUARD ||
                        head_pos >= TMS_TAPE_CELLS - TMS_EDGE_GUARD) begin
                        tick_q.push_back(make_report(KIND_EDGE, steps_done, '0));
                        halted = 1'b1;
                    end else if (steps_done >= budget_reg) begin
                        tick_q.push_back(make_report(KIND_BUDGET, steps_done, '0));
                        halted = 1'b1;
                    end
                end
            end
        end
        if (tick_q.size() > 0)
            tick_q[tick_q.size()-1].last = 1'b1;
        foreach (tick_q[k])
            expected_reports.push_back(tick_q[k]);
    endtask

    function automatic void check_field(string name, logic [47:0] want, logic [47:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    // input stream: one transaction per queued tick, random gap after each
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
            gap_cnt <= 0;
        end else begin
            if (s_valid && s_axis_tready)
                step_machine(s_data[0]);
            if (!s_valid || s_axis_tready) begin
                if (gap_cnt != 0) begin
                    gap_cnt <= gap_cnt - 1;
                    s_valid <= 1'b0;
                end else if (pending_runs.size() != 0) begin
                    s_valid <= 1'b1;
                    s_data  <= {7'd0, pending_runs.pop_front()};
                    gap_cnt <= $urandom_range(0, gap_max);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // configuration transactions update the predictor's registers
    always @(posedge i_clk) begin
        if (i_rst_n && cfg_valid && o_cfg_ready) begin
            case (cfg_index)
                TMS_CFG_TABLE:  rule_table = cfg_data[TMS_TABLE_W-1:0];
                TMS_CFG_TARGET: target_reg = cfg_data[TMS_TARGET_W-1:0];
                TMS_CFG_BUDGET: budget_reg = cfg_data[TMS_STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // result stream: check, then draw the stall before the next transaction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_ready   <= 1'b0;
            stall_cnt <= 0;
            hold_cnt  <= 0;
        end else begin
            if (m_axis_tvalid && m_ready) begin
                if (expected_reports.size() == 0) begin
                    $display("%0t: unexpected report, expected none, actual kind %0d step %0h",
                             $time, m_axis_tuser, m_axis_tdata[47:0]);
                    errors++;
                end else begin
                    oldest_report = expected_reports.pop_front();
                    check_field("kind", {46'd0, oldest_report.kind}, {46'd0, m_axis_tuser});
                    check_field("step_count", oldest_report.step_count, m_axis_tdata[47:0]);
                    check_field("head_offset", {28'd0, oldest_report.head_offset},
                                {28'd0, m_axis_tdata[67:48]});
                    check_field("low_extent", {28'd0, oldest_report.low_extent},
                                {28'd0, m_axis_tdata[87:68]});
                    check_field("high_extent", {28'd0, oldest_report.high_extent},
                                {28'd0, m_axis_tdata[107:88]});
                    check_field("last", {47'd0, oldest_report.last}, {47'd0, m_axis_tlast});
                end
            end
            if (hold_wanted && !hold_done) begin
                hold_done <= 1'b1;
                hold_cnt  <= LONG_HOLD;
                m_ready   <= 1'b0;
            end else if (hold_cnt != 0) begin
                hold_cnt <= hold_cnt - 1;
                m_ready  <= (hold_cnt == 1);
            end else if (m_axis_tvalid && m_ready) begin
                recv_draw = $urandom_range(0, stall_max);
                stall_cnt <= recv_draw;
                m_ready   <= (recv_draw == 0);
            end else if (stall_cnt != 0) begin
                stall_cnt <= stall_cnt - 1;
                m_ready   <= (stall_cnt == 1);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("[turing_machine_stepper_top] ERROR");
            $finish;
        end
    end

    // leaves valid high so back-to-back writes follow without a gap
    task automatic write_reg(input logic [TMS_IDX_W-1:0] idx, input logic [TMS_CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
    endtask

    task automatic load_setup(input logic [TMS_TABLE_W-1:0] rules,
                              input logic [TMS_TARGET_W-1:0] tgt,
                              input logic [TMS_STEP_W-1:0] bud);
        write_reg(TMS_CFG_TABLE, TMS_CFG_W'(rules));
        write_reg(TMS_CFG_TARGET, TMS_CFG_W'(tgt));
        write_reg(TMS_CFG_BUDGET, TMS_CFG_W'(bud));
        cfg_valid <= 1'b0;
    endtask

    // ticks with no report leave nothing queued, so allow the pipeline to drain
    task automatic wait_quiet();
        while (pending_runs.size() != 0 || s_valid || expected_reports.size() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic queue_ticks(input int count, input int idle_pct);
        logic run;
        for (int k = 0; k < count; k++) begin
            run = ($urandom_range(0, 99) >= idle_pct);
            pending_runs.push_back(run);
            if (run)
                runs_queued++;
        end
    endtask

    function automatic int pick_pace();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 3;
            default: return 19;
        endcase
    endfunction

    initial begin
        logic [TMS_TABLE_W-1:0] rules;
        logic [TMS_STEP_W-1:0]  bud;
        int                     phase;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // all-zero rules, target 0: fires every step while walking left
        load_setup('0, 3'd0, BUDGET_MAX);
        pending_runs.push_back(1'b0);
        pending_runs.push_back(1'b0);
        queue_ticks(10, 0);
        wait_quiet();

        // write 1 and move left on 0, right on 1, stepping through every state
        for (int e = 0; e < 8; e++)
            rules[5*e +: 5] = {1'b0, 2'(e / 2 + 1), 1'(e % 2), 1'b1};
        load_setup(rules, 3'd7, BUDGET_MAX);
        queue_ticks(12, 0);
        wait_quiet();

        // receiver stops for a long stretch while back-to-back fires pile up
        load_setup('0, 3'd0, BUDGET_MAX);
        hold_wanted = 1'b1;
        queue_ticks(40, 0);
        wait_quiet();

        phase = 0;
        while ((runs_queued < RUN_TARGET || fires_queued < FIRE_TARGET) && phase < 40) begin
            rules = TMS_TABLE_W'({$urandom, $urandom}) & NO_HALT_MASK;
            bud   = $urandom_range(0, 1) ? BUDGET_MAX
                                         : steps_done + 2000 + $urandom_range(0, 1 << 20);
            load_setup(rules, 3'($urandom_range(0, 7)), bud);
            gap_max   = pick_pace();
            stall_max = pick_pace();
            queue_ticks($urandom_range(20, 120), 10);
            wait_quiet();
            phase++;
        end

        // run out the budget: either during a step or already met on the next tick
        gap_max   = pick_pace();
        stall_max = pick_pace();
        bud = $urandom_range(0, 1) ? steps_done + 12
                                   : TMS_STEP_W'($urandom_range(0, int'(steps_done)));
        load_setup(TMS_TABLE_W'({$urandom, $urandom}) & NO_HALT_MASK,
                   3'($urandom_range(0, 7)), bud);
        queue_ticks(40, 10);
        wait_quiet();

        // finished: register extremes and further ticks must stay silent
        load_setup('1, 3'd7, '0);
        queue_ticks(6, 0);
        wait_quiet();
        repeat (10) @(posedge i_clk);

        if (errors == 0 && expected_reports.size() == 0)
            $display("[turing_machine_stepper_top] OK");
        else
            $display("[turing_machine_stepper_top] ERROR");
        $finish;
    end

endmodule

>>> turing_machine_stepper_top.f
hdl/tms_pkg.sv
hdl/tms_ram.sv
hdl/tms_core.sv
hdl/tms_out_fifo.sv
hdl/turing_machine_stepper_top.sv
tb/turing_machine_stepper_top_tb.sv
